// ----- sv/ffbpa_pkg.sv -----
// Package: shared types and constants for the first-fit bump pool allocator.
package ffbpa_pkg;

  localparam int unsigned MAX_ENTRIES = 128;
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ENT_W = 65;  // used, length, offset

  localparam logic [31:0] POOL_START_RST = 32'h0000_8000;
  localparam logic [31:0] POOL_END_RST   = 32'h0000_F000;

  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_FREE    = 3'd1;
  localparam logic [2:0] MODE_SIZE    = 3'd2;
  localparam logic [2:0] MODE_REALLOC = 3'd3;
  localparam logic [2:0] MODE_RESET   = 3'd4;

  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_END   = 1'b1;

  typedef struct packed {
    logic        used;
    logic [31:0] length;
    logic [31:0] offset;
  } entry_t;

  typedef struct packed {
    logic [31:0] copy_length;
    logic [31:0] copy_source;
    logic [31:0] zero_length;
    logic [31:0] size_found;
    logic [31:0] address;
  } result_t;

  function automatic logic [31:0] align_request(input logic [31:0] raw);
    logic [31:0] r;
    r = (raw == 32'd0 || raw[31]) ? 32'd1 : raw;
    return (r + 32'd3) & ~32'd3;
  endfunction

endpackage

// ----- sv/ffbpa_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module ffbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/ffbpa_engine.sv -----
// Scan/update sequencer: runs alloc, free, size and realloc over the entry table, plus pool reset.
module ffbpa_engine import ffbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [2:0]  mode,
  input  logic [31:0] pointer,
  input  logic [31:0] req_size,
  input  logic [31:0] pool_start,
  input  logic [31:0] pool_end,
  output logic        busy,
  output logic        done,
  output result_t     result
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_SIZE  = 7'b0000100,
    S_ALLOC = 7'b0001000,
    S_BUMP  = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      bump_r, bump_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rvld_r, rvld_nxt;   // read data valid for idx_r-1
  logic [2:0]       mode_r, mode_nxt;
  logic [31:0]      ptr_r, ptr_nxt;
  logic [31:0]      size_r, size_nxt;
  logic             rfree_r, rfree_nxt; // realloc with non-positive request
  logic [31:0]      old_r, old_nxt;
  result_t          res_r, res_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  logic [CNT_W-1:0] ridx;

  ffbpa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign result = res_r;
  assign raddr  = idx_r[IDX_W-1:0];
  assign ridx   = idx_r - CNT_W'(1);

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; bump_nxt = bump_r;
    idx_nxt = idx_r; rvld_nxt = 1'b0; mode_nxt = mode_r; ptr_nxt = ptr_r;
    size_nxt = size_r; rfree_nxt = rfree_r; old_nxt = old_r; res_nxt = res_r;
    we = 1'b0; waddr = ridx[IDX_W-1:0]; wdata = rdata;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = mode;
          ptr_nxt   = pointer;
          size_nxt  = align_request(req_size);
          rfree_nxt = (req_size == 32'd0) || req_size[31];
          res_nxt   = '0;
          idx_nxt   = '0;   // dispatch cycle reads entry 0
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        idx_nxt = '0;
        case (mode_r)
          MODE_ALLOC: state_nxt = S_ALLOC;
          MODE_FREE:  state_nxt = S_FREE;
          MODE_SIZE:  state_nxt = S_SIZE;
          MODE_REALLOC: begin
            if (ptr_r == 32'd0) state_nxt = S_ALLOC;
            else if (rfree_r) state_nxt = S_FREE;
            else state_nxt = S_SIZE;
          end
          MODE_RESET: begin
            count_nxt = '0; bump_nxt = pool_start; state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
        if (state_nxt == S_ALLOC || state_nxt == S_FREE || state_nxt == S_SIZE) begin
          idx_nxt = CNT_W'(1);
          rvld_nxt = 1'b1;
        end
        if ((state_nxt == S_FREE) && (ptr_r < pool_start || ptr_r >= pool_end)) begin
          state_nxt = S_DONE;
        end
      end
      // Scans: rdata is entry ridx when rvld_r; ridx < count_r checked.
      S_SIZE: begin
        if (!rvld_r || ridx >= count_r) begin
          old_nxt = '0;
          state_nxt = S_DONE;
        end else if (rdata.used && rdata.offset == ptr_r) begin
          old_nxt = rdata.length;
          if (mode_r == MODE_SIZE) begin
            res_nxt.size_found = rdata.length;
            state_nxt = S_DONE;
          end else if (rdata.length >= size_r) begin
            res_nxt.address = ptr_r;
            state_nxt = S_DONE;
          end else begin
            // alloc scan restarts from entry 0
            idx_nxt = '0; state_nxt = S_ALLOC;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1); rvld_nxt = (idx_r < CNT_W'(MAX_ENTRIES));
        end
      end
      S_ALLOC: begin
        if (!rvld_r || ridx >= count_r) begin
          state_nxt = S_BUMP;
        end else if (!rdata.used && rdata.length >= size_r) begin
          we = 1'b1;
          wdata.used = 1'b1;
          res_nxt.address = rdata.offset;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1); rvld_nxt = (idx_r < CNT_W'(MAX_ENTRIES));
        end
      end
      S_BUMP: begin
        if ({1'b0, bump_r} + {1'b0, size_r} > {1'b0, pool_end} ||
            count_r >= CNT_W'(MAX_ENTRIES)) begin
          state_nxt = S_DONE;
        end else begin
          we = 1'b1;
          waddr = count_r[IDX_W-1:0];
          wdata.used = 1'b1; wdata.length = size_r; wdata.offset = bump_r;
          res_nxt.address = bump_r;
          count_nxt = count_r + CNT_W'(1);
          bump_nxt = bump_r + size_r;
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        if (!rvld_r || ridx >= count_r) begin
          state_nxt = S_DONE;
        end else if (rdata.used && rdata.offset == ptr_r) begin
          we = 1'b1;
          wdata.used = 1'b0;
          if ({1'b0, ptr_r} + {1'b0, rdata.length} == {1'b0, bump_r}) begin
            bump_nxt = ptr_r;
            count_nxt = count_r - CNT_W'(1);
          end
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1); rvld_nxt = (idx_r < CNT_W'(MAX_ENTRIES));
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // Alloc success bookkeeping; moving realloc then frees the old block if it lies in the pool.
    if ((state_r == S_ALLOC || state_r == S_BUMP) && state_nxt == S_DONE &&
        res_nxt.address != 32'd0) begin
      res_nxt.zero_length = size_r;
      if (mode_r == MODE_REALLOC && ptr_r != 32'd0) begin
        res_nxt.copy_source = ptr_r;
        res_nxt.copy_length = old_r;
        if (ptr_r >= pool_start && ptr_r < pool_end) begin
          state_nxt = S_FREE;
          idx_nxt = '0;
          rvld_nxt = 1'b0;
        end
      end
    end
    // Chained scan restarts once entry 0 has been read.
    if ((state_r == S_FREE || state_r == S_ALLOC) && idx_r == '0 && !rvld_r) begin
      state_nxt = state_r; idx_nxt = CNT_W'(1); rvld_nxt = 1'b1;
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bump_r  <= POOL_START_RST;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bump_r  <= bump_nxt;
      rvld_r  <= rvld_nxt;
    end
    idx_r <= idx_nxt; mode_r <= mode_nxt; ptr_r <= ptr_nxt; size_r <= size_nxt;
    rfree_r <= rfree_nxt; old_r <= old_nxt; res_r <= res_nxt;
  end
endmodule

// ----- sv/first_fit_bump_pool_allocator.sv -----
// Top level: first-fit pool allocator with bump pointer, stream ports and config channel.
// Usage:
//  - in_ channel takes one request transaction: mode, pointer, req_size.
//  - out_ channel returns exactly one result transaction per request.
//  - cfg_ channel writes pool_start (index 0) and pool_end (index 1); write only
//    while idle. Writes never move the bump pointer.
// Each request walks the 128-entry table in a simple dual-port RAM with one
// read per cycle; realloc may chain size scan, alloc scan and free scan.
// The table scan through the RAM read port dominates how long a request takes.
// One request is in flight at a time; in_tready is low while the engine works.
// The result sits in an output register; in_tready stays low until that
// result transaction is taken, so a stalled receiver also stalls the input.
// Reset: synchronous, active low; entry count 0, bump pointer 0x8000, pool
// 0x8000..0xF000. The table needs no clearing: only entries below the count
// are read, and all of them were written.
// A stalled receiver just holds out_tvalid and data stable.
module first_fit_bump_pool_allocator import ffbpa_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // mode[2:0], pointer[34:3], req_size[66:35], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // address, size_found, zero_length, copy_source, copy_length
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  logic [31:0] pool_start_r, pool_end_r;
  logic        ovld_r;
  result_t     out_r;
  logic        busy, done, start;
  result_t     result;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy && !ovld_r;
  assign start     = in_tvalid && in_tready;

  ffbpa_engine u_eng (
    .clk(clk), .rst_n(rst_n), .start(start),
    .mode(in_tdata[2:0]), .pointer(in_tdata[34:3]), .req_size(in_tdata[66:35]),
    .pool_start(pool_start_r), .pool_end(pool_end_r),
    .busy(busy), .done(done), .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_start_r <= POOL_START_RST;
      pool_end_r   <= POOL_END_RST;
      ovld_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_POOL_START) pool_start_r <= cfg_data;
        else pool_end_r <= cfg_data;
      end
      if (done) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
    end
    if (done) out_r <= result;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accept while busy");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_tvalid) else $error("result lost");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy) else $error("engine did not start");
endmodule
